@@ rtl/core/ordered_set_range_sum_defines.svh @@
// assertion macros for the ordered set range sum block
`ifndef ORDERED_SET_RANGE_SUM_DEFINES_SVH
`define ORDERED_SET_RANGE_SUM_DEFINES_SVH

// clocked check, off while reset is asserted
`define OSRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds through reset
`define OSRS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/osrs_pkg.sv @@
package osrs_pkg;

  // table size and derived widths
  localparam int unsigned Capacity = 1024;
  localparam int unsigned AddrW    = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned KeyW     = 64;

  // request codes
  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_QUERY     = 2'd3
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

endpackage

@@ rtl/core/ordered_set_range_sum.sv @@
// Ordered set of distinct signed 64-bit keys with inclusive range-sum queries.
// Command channel: a word is taken on a rising edge with start high and busy
// low; command_i selects add (key in first_value_i) or query (bounds in
// first_value_i and upper_bound_i, signed, inclusive).
// Result channel: done_o is high for exactly one cycle with status_o and
// range_sum_o; the receiver cannot hold it off, and the word is gone after
// that cycle. range_sum_o is zero for add requests.
// Each request sweeps the key table once, one entry per cycle through the
// single read port of the synchronous key memory, then passes a finish state
// that raises done_o; busy stays high through the sweep and the finish state.
// The next word can be taken in the cycle that shows the result.
// An add that finds a new key writes it back at the end of the sweep; a full
// table drops it with status full, a duplicate is reported even when full.
// Reset empties the table by clearing the entry count; memory contents are
// left as they are and only entries below the count are ever read.
module ordered_set_range_sum
  import osrs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   command_i,
  input  logic signed [KeyW-1:0] first_value_i,
  input  logic signed [KeyW-1:0] upper_bound_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic signed [KeyW-1:0] range_sum_o
);

  // key memory
  logic [KeyW-1:0] mem [Capacity];

  state_e state_q, state_d;

  logic [CountW-1:0]     count_q, count_d;
  logic [CountW-1:0]     issue_q, issue_d;
  logic                  rd_vld_q, rd_vld_d;
  logic                  rd_en;
  logic [KeyW-1:0]       rd_data_q;
  logic                  wr_en;

  cmd_e                  cmd_q, cmd_d;
  logic signed [KeyW-1:0] first_q, first_d;
  logic signed [KeyW-1:0] upper_q, upper_d;
  logic                  found_q, found_d;
  logic [KeyW-1:0]       sum_q, sum_d;

  logic                  done_q, done_d;
  status_e               status_q, status_d;
  logic [KeyW-1:0]       res_q, res_d;

  logic signed [KeyW-1:0] key;
  logic                  key_eq;
  logic                  key_in_range;
  logic                  accept;

  assign accept = start && !busy;
  assign key    = $signed(rd_data_q);

  // compare the word coming back from memory
  assign key_eq       = (key == first_q);
  assign key_in_range = (first_q <= key) && (key <= upper_q);

  // memory write port, new key goes to the first free entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AddrW-1:0]] <= first_q;
    end
  end

  // memory read port, registered output
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[issue_q[AddrW-1:0]];
    end
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    issue_q  <= issue_d;
    cmd_q    <= cmd_d;
    first_q  <= first_d;
    upper_q  <= upper_d;
    found_q  <= found_d;
    sum_q    <= sum_d;
    status_q <= status_d;
    res_q    <= res_d;
  end

  // sequencer: sweep the table, then settle the result
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    issue_d  = issue_q;
    rd_vld_d = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    cmd_d    = cmd_q;
    first_d  = first_q;
    upper_d  = upper_q;
    found_d  = found_q;
    sum_d    = sum_q;
    done_d   = 1'b0;
    status_d = status_q;
    res_d    = res_q;

    // fold in the word read last cycle
    if (rd_vld_q) begin
      if (key_eq) begin
        found_d = 1'b1;
      end
      if (key_in_range) begin
        sum_d = sum_q + rd_data_q;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_e'(command_i);
          first_d = first_value_i;
          upper_d = upper_bound_i;
          found_d = 1'b0;
          sum_d   = '0;
          issue_d = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue_q < count_q) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          issue_d  = issue_q + CountW'(1);
        end else if (!rd_vld_q) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        done_d  = 1'b1;
        res_d   = '0;
        state_d = S_IDLE;
        if (cmd_q == CMD_QUERY) begin
          status_d = ST_QUERY;
          res_d    = sum_q;
        end else if (found_q) begin
          status_d = ST_DUPLICATE;
        end else if (count_q == CountW'(Capacity)) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_INSERTED;
          wr_en    = 1'b1;
          count_d  = count_q + CountW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs
  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign range_sum_o = $signed(res_q);

  // checks
  `include "ordered_set_range_sum_defines.svh"

  `OSRS_ASSERT(a_count_bound, count_q <= CountW'(Capacity), "entry count over capacity")
  `OSRS_ASSERT(a_add_zero_sum, done_o && (status_o != ST_QUERY) |-> range_sum_o == '0, "add gave nonzero sum")
  `OSRS_ASSERT(a_accept_busy, start && !busy |=> busy && !done_o, "accepted word did not start a sweep")
  `OSRS_ASSERT(a_insert_count, done_o && (status_o == ST_INSERTED) |-> count_q == $past(count_q) + CountW'(1), "insert did not bump count")
  `OSRS_ASSERT(a_done_after_busy, done_o |-> $past(busy) && !busy, "result without a sweep")

endmodule
